// File: sv/lsk_pkg.sv
package lsk_pkg;

    // Fixed field widths of the stream payload
    localparam int unsigned VAL_W    = 8;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned STATUS_W = 2;

    // Operation codes carried on the input tuser
    localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd3;

    // Status codes reported with every result
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BADPOS = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_DEL,
        ST_INS_SHIFT,
        ST_RESP
    } state_t;

endpackage

// File: sv/lsk_ram.sv
module lsk_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one read port with registered read data.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/lifo_stack_with_key_delete_insert.sv
// A push, a pop on an empty or one-entry stack and a refused or dropped insert go straight to
// the response state; any other pop first reads the new top, delete-key walks every entry and
// an insert shifts the entries from the top down to its cursor, both through the store's one
// read and one write port. One transaction at a time: the next is taken the cycle after its
// result is queued, and a result still waiting for m_tready holds the response state.
// Reset clears the count, the insert run, the top byte and m_tvalid; the store is not cleared.
module lifo_stack_with_key_delete_insert #(
    parameter int unsigned DEPTH = 64,
    localparam int unsigned CNT_W      = $clog2(DEPTH + 1),
    localparam int unsigned AW         = $clog2(DEPTH),
    localparam int unsigned IN_W       = lsk_pkg::VAL_W + CNT_W,
    localparam int unsigned IN_DATA_W  = ((IN_W + 7) / 8) * 8,
    localparam int unsigned OUT_W      = lsk_pkg::VAL_W + CNT_W + 2 + lsk_pkg::STATUS_W,
    localparam int unsigned OUT_DATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [IN_DATA_W-1:0]          s_tdata,   // value, position
    input  logic [lsk_pkg::MODE_W-1:0]    s_tuser,   // mode
    input  logic                          s_tlast,   // run_last
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_DATA_W-1:0]         m_tdata    // top_value, count, empty_res, full_res, status
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam int unsigned VW = lsk_pkg::VAL_W;

    lsk_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              cursor_reg, cursor_next;
    logic                          in_run_reg, in_run_next;
    logic [VW-1:0]                 top_reg, top_next;
    logic [lsk_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [VW-1:0]                 val_reg, val_next;
    logic [CNT_W-1:0]              rd_reg, rd_next;
    logic [CNT_W-1:0]              wr_reg, wr_next;
    logic [CNT_W-1:0]              sh_reg, sh_next;
    logic [AW-1:0]                 wa_reg, wa_next;
    logic                          pend_reg, pend_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]         m_tdata_reg, m_tdata_next;

    logic                          accept;
    logic [lsk_pkg::MODE_W-1:0]    in_mode;
    logic [VW-1:0]                 in_value;
    logic [CNT_W-1:0]              in_pos;
    logic                          in_last;
    logic                          is_full;
    logic                          is_empty;
    logic [CNT_W-1:0]              count_dec;
    logic [CNT_W-1:0]              cur_eff;
    logic                          keep;
    logic                          out_free;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [VW-1:0]                 ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic [VW-1:0]                 ram_rdata;

    // Stack store
    lsk_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Input field unpacking and common conditions.
    assign s_tready  = (state_reg == lsk_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign in_mode   = s_tuser;
    assign in_value  = s_tdata[VW-1:0];
    assign in_pos    = s_tdata[VW +: CNT_W];
    assign in_last   = s_tlast;
    assign is_full   = (count_reg == DEPTH_C);
    assign is_empty  = (count_reg == '0);
    assign count_dec = count_reg - 1'b1;
    assign cur_eff   = in_run_reg ? cursor_reg : in_pos;
    assign keep      = pend_reg && (ram_rdata != val_reg);
    assign out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lsk_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (in_mode)
                        lsk_pkg::MODE_PUSH: begin
                            state_next = lsk_pkg::ST_RESP;
                        end
                        lsk_pkg::MODE_POP: begin
                            if (!is_empty && (count_reg > CNT_W'(1))) begin
                                state_next = lsk_pkg::ST_POP_RD;
                            end else begin
                                state_next = lsk_pkg::ST_RESP;
                            end
                        end
                        lsk_pkg::MODE_DELETE: begin
                            state_next = lsk_pkg::ST_DEL;
                        end
                        lsk_pkg::MODE_INSERT: begin
                            if ((!in_run_reg && (in_pos > count_reg)) || (cur_eff > count_reg)
                                || is_full) begin
                                state_next = lsk_pkg::ST_RESP;
                            end else begin
                                state_next = lsk_pkg::ST_INS_SHIFT;
                            end
                        end
                    endcase
                end
            end
            lsk_pkg::ST_POP_RD: begin
                state_next = lsk_pkg::ST_RESP;
            end
            lsk_pkg::ST_DEL: begin
                if (rd_reg == count_reg) begin
                    state_next = lsk_pkg::ST_RESP;
                end
            end
            lsk_pkg::ST_INS_SHIFT: begin
                if ((sh_reg == cursor_reg) && !pend_reg) begin
                    state_next = lsk_pkg::ST_RESP;
                end
            end
            lsk_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = lsk_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lsk_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, memory port and result register control.
    always_comb begin
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        in_run_next   = in_run_reg;
        top_next      = top_reg;
        status_next   = status_reg;
        val_next      = val_reg;
        rd_next       = rd_reg;
        wr_next       = wr_reg;
        sh_next       = sh_reg;
        wa_next       = wa_reg;
        pend_next     = pend_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_raddr     = '0;

        unique case (state_reg)
            lsk_pkg::ST_IDLE: begin
                if (accept) begin
                    status_next = lsk_pkg::STATUS_OK;
                    unique case (in_mode)
                        lsk_pkg::MODE_PUSH: begin
                            in_run_next = 1'b0;
                            if (is_full) begin
                                status_next = lsk_pkg::STATUS_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                ram_wdata  = in_value;
                                count_next = count_reg + 1'b1;
                                top_next   = in_value;
                            end
                        end
                        lsk_pkg::MODE_POP: begin
                            in_run_next = 1'b0;
                            if (is_empty) begin
                                status_next = lsk_pkg::STATUS_EMPTY;
                            end else begin
                                count_next = count_dec;
                                // The new top sits just below the old one.
                                ram_raddr  = count_dec[AW-1:0] - 1'b1;
                                if (count_reg == CNT_W'(1)) begin
                                    top_next = '0;
                                end
                            end
                        end
                        lsk_pkg::MODE_DELETE: begin
                            in_run_next = 1'b0;
                            val_next    = in_value;
                            rd_next     = '0;
                            wr_next     = '0;
                            pend_next   = 1'b0;
                            top_next    = '0;
                        end
                        lsk_pkg::MODE_INSERT: begin
                            val_next = in_value;
                            if (!in_run_reg && (in_pos > count_reg)) begin
                                status_next = lsk_pkg::STATUS_BADPOS;
                            end else if (cur_eff > count_reg) begin
                                in_run_next = 1'b0;
                                status_next = lsk_pkg::STATUS_BADPOS;
                            end else begin
                                in_run_next = !in_last;
                                cursor_next = cur_eff;
                                if (is_full) begin
                                    status_next = lsk_pkg::STATUS_FULL;
                                end else begin
                                    sh_next   = count_reg;
                                    pend_next = 1'b0;
                                end
                            end
                        end
                    endcase
                end
            end
            lsk_pkg::ST_POP_RD: begin
                top_next = ram_rdata;
            end
            lsk_pkg::ST_DEL: begin
                // Compact the kept entries downwards, one read and one write per cycle.
                if (keep) begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_reg[AW-1:0];
                    ram_wdata = ram_rdata;
                    top_next  = ram_rdata;
                end
                wr_next = wr_reg + CNT_W'(keep);
                if (rd_reg != count_reg) begin
                    ram_raddr = rd_reg[AW-1:0];
                    rd_next   = rd_reg + 1'b1;
                    pend_next = 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    count_next = wr_reg + CNT_W'(keep);
                end
            end
            lsk_pkg::ST_INS_SHIFT: begin
                // Move entries up by one from the top down to the cursor.
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = wa_reg;
                    ram_wdata = ram_rdata;
                end
                if (sh_reg > cursor_reg) begin
                    ram_raddr = sh_reg[AW-1:0] - 1'b1;
                    wa_next   = sh_reg[AW-1:0];
                    sh_next   = sh_reg - 1'b1;
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        ram_we      = 1'b1;
                        ram_waddr   = cursor_reg[AW-1:0];
                        ram_wdata   = val_reg;
                        count_next  = count_reg + 1'b1;
                        cursor_next = cursor_reg + 1'b1;
                        if (cursor_reg == count_reg) begin
                            top_next = val_reg;
                        end
                    end
                end
            end
            lsk_pkg::ST_RESP: begin
                if (out_free) begin
                    m_tvalid_next                             = 1'b1;
                    m_tdata_next                              = '0;
                    m_tdata_next[VW-1:0]                      = top_reg;
                    m_tdata_next[VW +: CNT_W]                 = count_reg;
                    m_tdata_next[VW + CNT_W]                  = is_empty;
                    m_tdata_next[VW + CNT_W + 1]              = is_full;
                    m_tdata_next[VW + CNT_W + 2 +: lsk_pkg::STATUS_W] = status_reg;
                end
            end
            default: begin
                pend_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lsk_pkg::ST_IDLE;
            count_reg    <= '0;
            cursor_reg   <= '0;
            in_run_reg   <= 1'b0;
            top_reg      <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cursor_reg   <= cursor_next;
            in_run_reg   <= in_run_next;
            top_reg      <= top_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        val_reg     <= val_next;
        rd_reg      <= rd_next;
        wr_reg      <= wr_next;
        sh_reg      <= sh_next;
        wa_reg      <= wa_next;
        m_tdata_reg <= m_tdata_next;
    end

    // The count never goes beyond the store's depth.
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= DEPTH_C)
        else $error("stack count exceeds depth");

    // An open insert run always has its cursor within the held entries.
    assert property (@(posedge aclk) disable iff (!aresetn) in_run_reg |-> cursor_reg <= count_reg)
        else $error("insert cursor above count during a run");

    // Compaction never writes ahead of the read pointer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lsk_pkg::ST_DEL) |-> (wr_reg <= rd_reg) && (rd_reg <= count_reg))
        else $error("delete write pointer ahead of read pointer");

    // The shift walk stays between the cursor and the count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lsk_pkg::ST_INS_SHIFT) |-> (sh_reg >= cursor_reg) && (sh_reg <= count_reg))
        else $error("insert shift index out of range");

    // A result is only queued from the response state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid_reg && $past(aresetn))
            |=> (m_tvalid_reg |-> $past(state_reg == lsk_pkg::ST_RESP)))
        else $error("result raised outside the response state");

endmodule

// File: tb/tb_lifo_stack_with_key_delete_insert.sv
// Expected results of the stack, worked out transaction by transaction.
typedef struct packed {
    logic [1:0] status;
    logic       full_flag;
    logic       empty_flag;
    logic [6:0] count;
    logic [7:0] top;
} stack_report_t;

class stack_tracker;
    localparam int CAPACITY = 64;

    // Shadow of the stack contents and the insert run.
    logic [7:0]    store [CAPACITY];
    int            depth_used;
    int            cursor;
    bit            run_open;
    stack_report_t awaited_reports [$];
    int            errors;
    int            checked;
    int            mode_seen [4];
    int            status_seen [4];
    int            full_seen;

    function new();
        depth_used = 0;
        cursor     = 0;
        run_open   = 0;
        errors     = 0;
        checked    = 0;
        full_seen  = 0;
        foreach (mode_seen[i]) mode_seen[i] = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int pending();
        return awaited_reports.size();
    endfunction

    // One byte of an insert run; the position is only read when no run is open.
    function logic [1:0] insert_byte(logic [7:0] data, logic [6:0] pos, bit run_end);
        if (!run_open) begin
            if (int'(pos) > depth_used) return lsk_pkg::STATUS_BADPOS;
            cursor = int'(pos);
        end
        if (cursor > depth_used) begin
            run_open = 0;
            return lsk_pkg::STATUS_BADPOS;
        end
        run_open = !run_end;
        if (depth_used >= CAPACITY) return lsk_pkg::STATUS_FULL;
        for (int i = depth_used; i > cursor; i--) store[i] = store[i-1];
        store[cursor] = data;
        depth_used++;
        cursor++;
        return lsk_pkg::STATUS_OK;
    endfunction

    // Apply one accepted transaction and queue the report it must produce.
    function void note_request(logic [1:0] op, logic [7:0] data, logic [6:0] pos,
                               bit run_end);
        stack_report_t rep;
        logic [1:0]    st;
        int            wr;
        st = lsk_pkg::STATUS_OK;
        if (op != lsk_pkg::MODE_INSERT) run_open = 0;
        case (op)
            lsk_pkg::MODE_PUSH: begin
                if (depth_used >= CAPACITY) begin
                    st = lsk_pkg::STATUS_FULL;
                end else begin
                    store[depth_used] = data;
                    depth_used++;
                end
            end
            lsk_pkg::MODE_POP: begin
                if (depth_used == 0) st = lsk_pkg::STATUS_EMPTY;
                else depth_used--;
            end
            lsk_pkg::MODE_DELETE: begin
                wr = 0;
                for (int i = 0; i < depth_used; i++) begin
                    if (store[i] != data) begin
                        store[wr] = store[i];
                        wr++;
                    end
                end
                depth_used = wr;
            end
            default: st = insert_byte(data, pos, run_end);
        endcase
        rep.top        = (depth_used > 0) ? store[depth_used-1] : 8'd0;
        rep.count      = depth_used[6:0];
        rep.empty_flag = (depth_used == 0);
        rep.full_flag  = (depth_used >= CAPACITY);
        rep.status     = st;
        mode_seen[op]++;
        status_seen[st]++;
        if (rep.full_flag) full_seen++;
        awaited_reports.push_back(rep);
    endfunction

    function void compare_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compare one accepted result with the oldest awaited report.
    function void check_report(logic [23:0] word);
        stack_report_t want;
        stack_report_t got;
        if (awaited_reports.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %h", $time, word);
            errors++;
            return;
        end
        want = awaited_reports.pop_front();
        got  = stack_report_t'(word[18:0]);
        checked++;
        compare_field("top_value", want.top, got.top);
        compare_field("count", want.count, got.count);
        compare_field("empty_res", want.empty_flag, got.empty_flag);
        compare_field("full_res", want.full_flag, got.full_flag);
        compare_field("status", want.status, got.status);
    endfunction
endclass

module tb_lifo_stack_with_key_delete_insert;

    localparam int DEPTH        = 64;
    localparam int ITEMS_TARGET = 1350;
    localparam int LIMIT_CYCLES = 1000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // value, position
    logic [1:0]  s_tuser;   // mode
    logic        s_tlast;   // run_last
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // top_value, count, empty_res, full_res, status

    stack_tracker tracker;
    int           items_sent;
    int           cycle_count;
    bit           tx_gaps;
    bit           rx_stalls;

    lifo_stack_with_key_delete_insert #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Clock and known input levels from time zero.
    initial begin
        aclk      = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = lsk_pkg::MODE_PUSH;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        tracker   = new();
    end

    always #4 aclk = ~aclk;

    // Watchdog on the total run length.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: random stalls before each transaction, then check it.
    initial begin
        int stall;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = rx_stalls ? $urandom_range(0, 12) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            tracker.check_report(m_tdata);
        end
    end

    // Send one transaction, after a random gap when gaps are enabled.
    task automatic send_item(input logic [1:0] op, input logic [7:0] data,
                             input logic [6:0] pos, input bit run_end);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pos, data};
        s_tuser  <= op;
        s_tlast  <= run_end;
        do @(posedge aclk); while (!s_tready);
        tracker.note_request(op, data, pos, run_end);
        items_sent++;
    endtask

    // Hold off the input until every awaited result has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.pending() != 0);
    endtask

    // Bytes lean towards a few repeated values so that deletes remove several.
    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 8'($urandom_range(0, 255));
        if (r < 80) return 8'($urandom_range(0, 7));
        return (r < 90) ? 8'h00 : 8'hFF;
    endfunction

    // Mostly a key that is held in the stack.
    function automatic logic [7:0] pick_key();
        if (tracker.depth_used > 0 && $urandom_range(0, 99) < 60)
            return tracker.store[$urandom_range(0, tracker.depth_used - 1)];
        return rand_byte();
    endfunction

    // Start of a run: mostly a valid position, sometimes a position above the count.
    function automatic logic [6:0] pick_start();
        if ($urandom_range(0, 99) < 85)
            return 7'($urandom_range(0, tracker.depth_used));
        return 7'($urandom_range(tracker.depth_used + 1, 127));
    endfunction

    // A run of inserts; later positions are don't-care, and a push may break it.
    task automatic send_insert_run(input int len);
        logic [6:0] first_pos;
        first_pos = pick_start();
        for (int i = 0; i < len; i++) begin
            if (i > 0 && $urandom_range(0, 99) < 4)
                send_item(lsk_pkg::MODE_PUSH, rand_byte(), 7'd0, 1'b0);
            send_item(lsk_pkg::MODE_INSERT, rand_byte(),
                      (i == 0) ? first_pos : 7'($urandom_range(0, 127)), i == len - 1);
        end
    endtask

    // Stimulus.
    initial begin
        int phase_kind;
        int phase_end;
        int r;
        int push_w;
        int pop_w;
        int del_w;
        items_sent = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty-stack cases, extremes, runs and broken runs.
        send_item(lsk_pkg::MODE_POP, 8'h00, 7'd0, 1'b0);
        send_item(lsk_pkg::MODE_DELETE, 8'h00, 7'd0, 1'b0);
        send_item(lsk_pkg::MODE_INSERT, 8'h11, 7'd1, 1'b1);
        send_item(lsk_pkg::MODE_INSERT, 8'h22, 7'd127, 1'b1);
        send_item(lsk_pkg::MODE_PUSH, 8'h00, 7'd0, 1'b0);
        send_item(lsk_pkg::MODE_PUSH, 8'hFF, 7'd0, 1'b0);
        send_item(lsk_pkg::MODE_PUSH, 8'hA5, 7'd0, 1'b0);
        send_item(lsk_pkg::MODE_PUSH, 8'hFF, 7'd0, 1'b1);
        send_item(lsk_pkg::MODE_DELETE, 8'hFF, 7'd0, 1'b0);
        send_item(lsk_pkg::MODE_DELETE, 8'h11, 7'd0, 1'b0);
        send_item(lsk_pkg::MODE_INSERT, 8'h5A, 7'd0, 1'b0);
        send_item(lsk_pkg::MODE_INSERT, 8'h3C, 7'd0, 1'b1);
        send_item(lsk_pkg::MODE_INSERT, 8'h77, 7'd4, 1'b1);
        // A push in the middle closes the run, so the next insert starts afresh.
        send_item(lsk_pkg::MODE_INSERT, 8'h01, 7'd2, 1'b0);
        send_item(lsk_pkg::MODE_PUSH, 8'h7E, 7'd0, 1'b0);
        send_item(lsk_pkg::MODE_INSERT, 8'h02, 7'd0, 1'b1);
        // Inside an open run the position field is ignored.
        send_item(lsk_pkg::MODE_INSERT, 8'h03, 7'd1, 1'b0);
        send_item(lsk_pkg::MODE_INSERT, 8'h04, 7'd127, 1'b1);
        send_item(lsk_pkg::MODE_INSERT, 8'h05, 7'd64, 1'b1);
        send_item(lsk_pkg::MODE_INSERT, 8'h06, 7'h55, 1'b1);
        send_item(lsk_pkg::MODE_INSERT, 8'h07, 7'h2A, 1'b0);
        send_item(lsk_pkg::MODE_POP, 8'h00, 7'd0, 1'b0);
        send_item(lsk_pkg::MODE_POP, 8'h00, 7'd0, 1'b0);
        drain_results();

        // Random phases: fill to full, drain, mixed and insert-heavy.
        while (items_sent < ITEMS_TARGET) begin
            phase_kind = $urandom_range(0, 3);
            tx_gaps    = ($urandom_range(0, 3) != 0);
            rx_stalls  = ($urandom_range(0, 3) != 0);
            case (phase_kind)
                0:       begin push_w = 60; pop_w = 65; del_w = 70; end
                1:       begin push_w = 15; pop_w = 70; del_w = 85; end
                2:       begin push_w = 30; pop_w = 55; del_w = 70; end
                default: begin push_w = 10; pop_w = 20; del_w = 30; end
            endcase
            phase_end = items_sent + $urandom_range(40, 120);
            while (items_sent < phase_end && items_sent < ITEMS_TARGET) begin
                r = $urandom_range(0, 99);
                if (r < push_w) begin
                    send_item(lsk_pkg::MODE_PUSH, rand_byte(), 7'($urandom_range(0, 127)),
                              1'($urandom_range(0, 1)));
                end else if (r < pop_w) begin
                    send_item(lsk_pkg::MODE_POP, rand_byte(), 7'($urandom_range(0, 127)),
                              1'($urandom_range(0, 1)));
                end else if (r < del_w) begin
                    send_item(lsk_pkg::MODE_DELETE, pick_key(), 7'($urandom_range(0, 127)),
                              1'($urandom_range(0, 1)));
                end else if ($urandom_range(0, 99) < 5) begin
                    // Lone insert with arbitrary fields.
                    send_item(lsk_pkg::MODE_INSERT, rand_byte(), 7'($urandom_range(0, 127)),
                              1'($urandom_range(0, 1)));
                end else begin
                    send_insert_run($urandom_range(1, 6));
                end
            end
            if ($urandom_range(0, 2) == 0) drain_results();
        end

        // Wait out the last results, then allow for any stray one.
        drain_results();
        repeat (80) @(posedge aclk);

        $display("Sent %0d transactions (push %0d, pop %0d, delete %0d, insert %0d), %0d checked.",
                 items_sent, tracker.mode_seen[lsk_pkg::MODE_PUSH],
                 tracker.mode_seen[lsk_pkg::MODE_POP], tracker.mode_seen[lsk_pkg::MODE_DELETE],
                 tracker.mode_seen[lsk_pkg::MODE_INSERT], tracker.checked);
        $display("Status ok %0d, pop on empty %0d, full dropped %0d, bad position %0d; full %0d.",
                 tracker.status_seen[lsk_pkg::STATUS_OK],
                 tracker.status_seen[lsk_pkg::STATUS_EMPTY],
                 tracker.status_seen[lsk_pkg::STATUS_FULL],
                 tracker.status_seen[lsk_pkg::STATUS_BADPOS], tracker.full_seen);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
